// File: design/hsv_pkg.sv
// types and constants shared by the hsv to rgb converter
`default_nettype none

package hsv_pkg;

    localparam int HUE_W = 9;
    localparam int PCT_W = 8;
    localparam int LVL_W = 8;

    localparam logic [HUE_W-1:0] HUE_WRAP  = 9'd360;
    localparam logic [PCT_W-1:0] PCT_FULL  = 8'd100;
    localparam logic [5:0]       DEG_SECTOR = 6'd60;
    localparam logic [12:0]      SPAN      = 13'd6000;

    localparam logic [HUE_W-1:0] HUE_SEC1 = 9'd60;
    localparam logic [HUE_W-1:0] HUE_SEC2 = 9'd120;
    localparam logic [HUE_W-1:0] HUE_SEC3 = 9'd180;
    localparam logic [HUE_W-1:0] HUE_SEC4 = 9'd240;
    localparam logic [HUE_W-1:0] HUE_SEC5 = 9'd300;

    // divisors and reciprocal estimates, floor(2^shift / divisor)
    localparam logic [27:0] DIV_Q   = 28'd600000;
    localparam logic [8:0]  RECIP_Q = 9'd447;
    localparam int          SHIFT_Q = 28;
    localparam logic [21:0] DIV_P   = 22'd10000;
    localparam logic [8:0]  RECIP_P = 9'd419;
    localparam int          SHIFT_P = 22;
    localparam logic [14:0] DIV_V   = 15'd100;
    localparam logic [8:0]  RECIP_V = 9'd327;
    localparam int          SHIFT_V = 15;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [PCT_W-1:0] sat_pct;
        logic [PCT_W-1:0] val_pct;
    } t_hsv_req;

    typedef struct packed {
        logic [LVL_W-1:0] red_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] blue_level;
    } t_rgb_res;

endpackage

`default_nettype wire

// File: design/hsv_to_rgb_converter.sv
// hsv to rgb converter: seven stage pipeline from hsv request to rgb levels
`default_nettype none

// One request per clock. o_busy is always low, so a request is taken whenever
// i_start is high; its result appears with o_valid once it has passed the
// pipeline stages in order: hue wrap and clamp, sector split, numerator
// terms, the scaling multiplies, a reciprocal estimate of each constant
// division, the remainder check and the final correction and channel
// select. Results are not held, the receiver takes each one in the
// cycle it is shown.
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_hsv_req i_req,
    output logic          o_busy,
    output logic          o_valid,
    output t_rgb_res      o_res
);

    // stage 1: hue wrap and clamp
    logic             r_s1_vld, n_s1_vld;
    logic [HUE_W-1:0] r_s1_hue, n_s1_hue;
    logic [6:0]       r_s1_sat, n_s1_sat;
    logic [6:0]       r_s1_val, n_s1_val;

    // stage 2: sector and remainder
    logic             r_s2_vld;
    t_sector          r_s2_sec, n_s2_sec;
    logic [5:0]       r_s2_rem, n_s2_rem;
    logic [6:0]       r_s2_sat;
    logic [6:0]       r_s2_val;

    // stage 3: numerator terms
    logic             r_s3_vld;
    t_sector          r_s3_sec;
    logic [12:0]      r_s3_nq, n_s3_nq;
    logic [12:0]      r_s3_nt, n_s3_nt;
    logic [6:0]       r_s3_np, n_s3_np;
    logic [14:0]      r_s3_v255, n_s3_v255;

    // stage 4: scaled products
    logic             r_s4_vld;
    t_sector          r_s4_sec;
    logic [27:0]      r_s4_xq, n_s4_xq;
    logic [27:0]      r_s4_xt, n_s4_xt;
    logic [21:0]      r_s4_xp, n_s4_xp;
    logic [14:0]      r_s4_xv;

    // stage 5: quotient estimates
    logic             r_s5_vld;
    t_sector          r_s5_sec;
    logic [27:0]      r_s5_xq;
    logic [27:0]      r_s5_xt;
    logic [21:0]      r_s5_xp;
    logic [14:0]      r_s5_xv;
    logic [36:0]      n_prod_q, n_prod_t;
    logic [30:0]      n_prod_p;
    logic [23:0]      n_prod_v;
    logic [LVL_W-1:0] r_s5_eq, r_s5_et, r_s5_ep, r_s5_ev;

    // stage 6: remainders
    logic             r_s6_vld;
    t_sector          r_s6_sec;
    logic [LVL_W-1:0] r_s6_eq, r_s6_et, r_s6_ep, r_s6_ev;
    logic [27:0]      r_s6_rq, n_s6_rq;
    logic [27:0]      r_s6_rt, n_s6_rt;
    logic [21:0]      r_s6_rp, n_s6_rp;
    logic [14:0]      r_s6_rv, n_s6_rv;

    // stage 7: correction and channel select
    logic [LVL_W-1:0] n_lq, n_lt, n_lp, n_lv;
    t_rgb_res         n_res;
    logic             r_out_vld;
    t_rgb_res         r_out_res;

    assign o_busy  = 1'b0;
    assign o_valid = r_out_vld;
    assign o_res   = r_out_res;

    assign n_s1_vld = i_start;

    always_comb begin
        n_s1_hue = (i_req.hue_deg >= HUE_WRAP) ? i_req.hue_deg - HUE_WRAP : i_req.hue_deg;
        n_s1_sat = (i_req.sat_pct > PCT_FULL) ? PCT_FULL[6:0] : i_req.sat_pct[6:0];
        n_s1_val = (i_req.val_pct > PCT_FULL) ? PCT_FULL[6:0] : i_req.val_pct[6:0];
    end

    always_comb begin
        priority if (r_s1_hue >= HUE_SEC5) begin
            n_s2_sec = SEC_5;
            n_s2_rem = 6'(r_s1_hue - HUE_SEC5);
        end else if (r_s1_hue >= HUE_SEC4) begin
            n_s2_sec = SEC_4;
            n_s2_rem = 6'(r_s1_hue - HUE_SEC4);
        end else if (r_s1_hue >= HUE_SEC3) begin
            n_s2_sec = SEC_3;
            n_s2_rem = 6'(r_s1_hue - HUE_SEC3);
        end else if (r_s1_hue >= HUE_SEC2) begin
            n_s2_sec = SEC_2;
            n_s2_rem = 6'(r_s1_hue - HUE_SEC2);
        end else if (r_s1_hue >= HUE_SEC1) begin
            n_s2_sec = SEC_1;
            n_s2_rem = 6'(r_s1_hue - HUE_SEC1);
        end else begin
            n_s2_sec = SEC_0;
            n_s2_rem = r_s1_hue[5:0];
        end
    end

    always_comb begin
        n_s3_nq   = SPAN - ({6'd0, r_s2_sat} * {7'd0, r_s2_rem});
        n_s3_nt   = SPAN - ({6'd0, r_s2_sat} * {7'd0, DEG_SECTOR - r_s2_rem});
        n_s3_np   = PCT_FULL[6:0] - r_s2_sat;
        n_s3_v255 = {r_s2_val, 8'd0} - {8'd0, r_s2_val};
    end

    always_comb begin
        n_s4_xq = {13'd0, r_s3_v255} * {15'd0, r_s3_nq};
        n_s4_xt = {13'd0, r_s3_v255} * {15'd0, r_s3_nt};
        n_s4_xp = {7'd0, r_s3_v255} * {15'd0, r_s3_np};
    end

    // estimates may be one low, never high
    always_comb begin
        n_prod_q = {9'd0, r_s4_xq} * {28'd0, RECIP_Q};
        n_prod_t = {9'd0, r_s4_xt} * {28'd0, RECIP_Q};
        n_prod_p = {9'd0, r_s4_xp} * {22'd0, RECIP_P};
        n_prod_v = {9'd0, r_s4_xv} * {15'd0, RECIP_V};
    end

    always_comb begin
        n_s6_rq = r_s5_xq - ({20'd0, r_s5_eq} * DIV_Q);
        n_s6_rt = r_s5_xt - ({20'd0, r_s5_et} * DIV_Q);
        n_s6_rp = r_s5_xp - ({14'd0, r_s5_ep} * DIV_P);
        n_s6_rv = r_s5_xv - ({7'd0, r_s5_ev} * DIV_V);
    end

    always_comb begin
        n_lq = (r_s6_rq >= DIV_Q) ? r_s6_eq + 8'd1 : r_s6_eq;
        n_lt = (r_s6_rt >= DIV_Q) ? r_s6_et + 8'd1 : r_s6_et;
        n_lp = (r_s6_rp >= DIV_P) ? r_s6_ep + 8'd1 : r_s6_ep;
        n_lv = (r_s6_rv >= DIV_V) ? r_s6_ev + 8'd1 : r_s6_ev;
        unique case (r_s6_sec)
            SEC_0: n_res = '{red_level: n_lv, green_level: n_lt, blue_level: n_lp};
            SEC_1: n_res = '{red_level: n_lq, green_level: n_lv, blue_level: n_lp};
            SEC_2: n_res = '{red_level: n_lp, green_level: n_lv, blue_level: n_lt};
            SEC_3: n_res = '{red_level: n_lp, green_level: n_lq, blue_level: n_lv};
            SEC_4: n_res = '{red_level: n_lt, green_level: n_lp, blue_level: n_lv};
            default: n_res = '{red_level: n_lv, green_level: n_lp, blue_level: n_lq};
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_out_vld <= r_s6_vld;
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        r_s1_hue  <= n_s1_hue;
        r_s1_sat  <= n_s1_sat;
        r_s1_val  <= n_s1_val;

        r_s2_sec  <= n_s2_sec;
        r_s2_rem  <= n_s2_rem;
        r_s2_sat  <= r_s1_sat;
        r_s2_val  <= r_s1_val;

        r_s3_sec  <= r_s2_sec;
        r_s3_nq   <= n_s3_nq;
        r_s3_nt   <= n_s3_nt;
        r_s3_np   <= n_s3_np;
        r_s3_v255 <= n_s3_v255;

        r_s4_sec  <= r_s3_sec;
        r_s4_xq   <= n_s4_xq;
        r_s4_xt   <= n_s4_xt;
        r_s4_xp   <= n_s4_xp;
        r_s4_xv   <= r_s3_v255;

        r_s5_sec  <= r_s4_sec;
        r_s5_xq   <= r_s4_xq;
        r_s5_xt   <= r_s4_xt;
        r_s5_xp   <= r_s4_xp;
        r_s5_xv   <= r_s4_xv;
        r_s5_eq   <= n_prod_q[SHIFT_Q +: LVL_W];
        r_s5_et   <= n_prod_t[SHIFT_Q +: LVL_W];
        r_s5_ep   <= n_prod_p[SHIFT_P +: LVL_W];
        r_s5_ev   <= n_prod_v[SHIFT_V +: LVL_W];

        r_s6_sec  <= r_s5_sec;
        r_s6_eq   <= r_s5_eq;
        r_s6_et   <= r_s5_et;
        r_s6_ep   <= r_s5_ep;
        r_s6_ev   <= r_s5_ev;
        r_s6_rq   <= n_s6_rq;
        r_s6_rt   <= n_s6_rt;
        r_s6_rp   <= n_s6_rp;
        r_s6_rv   <= n_s6_rv;

        r_out_res <= n_res;
    end

endmodule

`default_nettype wire

// File: verif/hsv_to_rgb_checker.sv
// checker for the hsv to rgb converter: predicts each request's levels and compares results
`default_nettype none

module rgb_level_checker
    import hsv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_busy,
    input  wire t_hsv_req i_req,
    input  wire logic     i_valid,
    input  wire t_rgb_res i_res,
    output int            o_fail_count,
    output int            o_pending
);

    localparam int unsigned LVL_FULL = 255;
    localparam int          REPORT_MAX = 10;

    t_rgb_res rgb_expected[$];
    t_rgb_res rgb_want;

    function automatic t_rgb_res predict_rgb(input t_hsv_req req);
        int unsigned hue;
        int unsigned sat;
        int unsigned val;
        int unsigned rem;
        int unsigned lv;
        int unsigned lp;
        int unsigned lq;
        int unsigned lt;
        t_sector     sector;
        t_rgb_res    rgb;
        hue = req.hue_deg % HUE_WRAP;
        sat = (req.sat_pct > PCT_FULL) ? PCT_FULL : req.sat_pct;
        val = (req.val_pct > PCT_FULL) ? PCT_FULL : req.val_pct;
        sector = t_sector'(hue / DEG_SECTOR);
        rem = hue % DEG_SECTOR;
        lv = (LVL_FULL * val) / PCT_FULL;
        lp = (LVL_FULL * val * (PCT_FULL - sat)) / (PCT_FULL * PCT_FULL);
        lq = (LVL_FULL * val * (SPAN - sat * rem)) / (SPAN * PCT_FULL);
        lt = (LVL_FULL * val * (SPAN - sat * (DEG_SECTOR - rem))) / (SPAN * PCT_FULL);
        if (sat == 0) begin
            rgb = '{red_level: lv[7:0], green_level: lv[7:0], blue_level: lv[7:0]};
        end else begin
            case (sector)
                SEC_0: rgb = '{red_level: lv[7:0], green_level: lt[7:0], blue_level: lp[7:0]};
                SEC_1: rgb = '{red_level: lq[7:0], green_level: lv[7:0], blue_level: lp[7:0]};
                SEC_2: rgb = '{red_level: lp[7:0], green_level: lv[7:0], blue_level: lt[7:0]};
                SEC_3: rgb = '{red_level: lp[7:0], green_level: lq[7:0], blue_level: lv[7:0]};
                SEC_4: rgb = '{red_level: lt[7:0], green_level: lp[7:0], blue_level: lv[7:0]};
                default: rgb = '{red_level: lv[7:0], green_level: lp[7:0], blue_level: lq[7:0]};
            endcase
        end
        return rgb;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= REPORT_MAX) begin
            $display("%0t rgb level mismatch on %s: expected %0d, got %0d", $realtime, what, want,
                     got);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                if (rgb_expected.size() == 0) begin
                    flag_mismatch("unrequested result", 0, i_res);
                end else begin
                    rgb_want = rgb_expected.pop_front();
                    if (i_res.red_level !== rgb_want.red_level) begin
                        flag_mismatch("red_level", rgb_want.red_level, i_res.red_level);
                    end
                    if (i_res.green_level !== rgb_want.green_level) begin
                        flag_mismatch("green_level", rgb_want.green_level, i_res.green_level);
                    end
                    if (i_res.blue_level !== rgb_want.blue_level) begin
                        flag_mismatch("blue_level", rgb_want.blue_level, i_res.blue_level);
                    end
                end
            end
            if (i_start && !i_busy) begin
                rgb_expected.push_back(predict_rgb(i_req));
            end
            o_pending <= rgb_expected.size();
        end
    end

endmodule

`default_nettype wire

// File: verif/hsv_to_rgb_converter_tb.sv
// testbench top for the hsv to rgb converter: request stimulus and verdict
`default_nettype none

module hsv_to_rgb_converter_tb;
    import hsv_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    t_hsv_req req;
    wire      busy;
    wire      valid;
    t_rgb_res res;
    int       n_failed;
    int       n_pending;

    t_hsv_req request_plan[$];

    hsv_to_rgb_converter dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_start(start),
        .i_req  (req),
        .o_busy (busy),
        .o_valid(valid),
        .o_res  (res)
    );

    rgb_level_checker rgb_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (req),
        .i_valid     (valid),
        .i_res       (res),
        .o_fail_count(n_failed),
        .o_pending   (n_pending)
    );

    function automatic t_hsv_req hsv(input int unsigned h, input int unsigned s,
                                     input int unsigned v);
        t_hsv_req r;
        r.hue_deg = h[HUE_W-1:0];
        r.sat_pct = s[PCT_W-1:0];
        r.val_pct = v[PCT_W-1:0];
        return r;
    endfunction

    // mostly in-range percentages, with zeros and overrange values mixed in
    function automatic int unsigned random_pct();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            return 0;
        end else if (pick < 15) begin
            return $urandom_range(1, 100);
        end
        return $urandom_range(0, 255);
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(12 * 200000);
        $display("[hsv_to_rgb_converter] ERROR");
        $finish;
    end

    initial begin
        int unsigned burst;
        int unsigned gap;
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;

        // sector edges, hue wrap, clamping, grey and black
        request_plan.push_back(hsv(0, 100, 100));
        request_plan.push_back(hsv(59, 100, 100));
        request_plan.push_back(hsv(60, 100, 100));
        request_plan.push_back(hsv(119, 100, 100));
        request_plan.push_back(hsv(120, 100, 100));
        request_plan.push_back(hsv(180, 100, 100));
        request_plan.push_back(hsv(240, 100, 100));
        request_plan.push_back(hsv(300, 100, 100));
        request_plan.push_back(hsv(359, 100, 100));
        request_plan.push_back(hsv(360, 100, 100));
        request_plan.push_back(hsv(361, 50, 50));
        request_plan.push_back(hsv(419, 80, 60));
        request_plan.push_back(hsv(420, 80, 60));
        request_plan.push_back(hsv(511, 255, 255));
        request_plan.push_back(hsv(511, 0, 255));
        request_plan.push_back(hsv(0, 0, 0));
        request_plan.push_back(hsv(90, 0, 73));
        request_plan.push_back(hsv(45, 100, 0));
        request_plan.push_back(hsv(30, 101, 101));
        request_plan.push_back(hsv(200, 255, 100));
        request_plan.push_back(hsv(330, 37, 255));
        request_plan.push_back(hsv(1, 1, 1));
        request_plan.push_back(hsv(150, 50, 100));
        request_plan.push_back(hsv(270, 99, 99));
        request_plan.push_back(hsv(0, 255, 0));
        repeat (700) begin
            request_plan.push_back(hsv($urandom_range(0, 511), random_pct(), random_pct()));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        while (request_plan.size() != 0) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            while (burst != 0 && request_plan.size() != 0) begin
                start <= 1'b1;
                req   <= request_plan.pop_front();
                do @(posedge clk); while (busy);
                burst = burst - 1;
            end
            start <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end

        while (n_pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);

        if (n_failed == 0 && n_pending == 0) begin
            $display("[hsv_to_rgb_converter] OK");
        end else begin
            $display("[hsv_to_rgb_converter] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
design/hsv_pkg.sv
design/hsv_to_rgb_converter.sv
verif/hsv_to_rgb_checker.sv
verif/hsv_to_rgb_converter_tb.sv
